// ===== sv/stpr_pkg.sv =====
// Shared types and constants for the spanning tree port role block.
`timescale 1ns / 1ps
package stpr_pkg;
    localparam int MAX_SWITCHES = 32;
    localparam int MAX_LINKS = 32;
    localparam int PORT_BITS = 12;
    localparam int SW_BITS = $clog2(MAX_SWITCHES);
    localparam int LK_BITS = $clog2(MAX_LINKS);
    localparam int CNT_BITS = 6;
    localparam int DIST_BITS = 6;

    typedef struct packed {
        logic [4:0]  end_a_switch;
        logic [11:0] end_a_port;
        logic [4:0]  end_b_switch;
        logic [11:0] end_b_port;
        logic        last_link;
    } link_word_t;

    typedef struct packed {
        logic [4:0] link_index;
        logic       a_root_port;
        logic       a_designated;
        logic       a_blocked;
        logic       b_root_port;
        logic       b_designated;
        logic       b_blocked;
        logic       last_result;
    } role_word_t;

    typedef enum logic [9:0] {
        ST_LOAD   = 10'b0000000001,
        ST_ADJ    = 10'b0000000010,
        ST_SEL    = 10'b0000000100,
        ST_RELAX  = 10'b0000001000,
        ST_RPSW   = 10'b0000010000,
        ST_RPLINK = 10'b0000100000,
        ST_RPSET  = 10'b0001000000,
        ST_DESIG  = 10'b0010000000,
        ST_EMIT   = 10'b0100000000,
        ST_WAIT   = 10'b1000000000
    } state_t;
endpackage

// ===== sv/spanning_tree_port_roles.sv =====
// Top level: link loading, shortest-path search and port role election.
//
// Usage: link words enter on s_ (valid/ready); a word with last_link set
// starts the election over all stored links (up to 32; extra words are
// dropped but last_link still counts). The user must write switch_count
// on cfg_ only while idle; the block itself does not enforce this. Results
// leave on m_ (valid/ready), one word per stored link, in load order,
// last_result set on the final one. Computation: the adjacency build walks
// the links in turn, the search makes one select pass and one relax pass
// over the N switches per visited switch (one compare unit), root port
// election makes a pass over the links for each reached switch (one link
// compare per cycle), role assignment walks the links once, and emit loads
// each word, then holds it until the handshake. s_ready is low from the last
// word until the final result is taken. A stalled m_ready holds the result
// word; nothing is lost. Reset (aresetn low, synchronous) empties the link
// table and sets switch_count to 1. The table needs no clearing pass.
`timescale 1ns / 1ps
module spanning_tree_port_roles import stpr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  link_word_t s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output role_word_t m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] cfg_data
);
    state_t state_reg;
    logic [5:0] count_reg;
    logic [CNT_BITS-1:0] total_reg;
    logic [5:0] n_act;

    // link table
    logic [SW_BITS-1:0]   la_sw [MAX_LINKS];
    logic [SW_BITS-1:0]   lb_sw [MAX_LINKS];
    logic [PORT_BITS-1:0] la_pt [MAX_LINKS];
    logic [PORT_BITS-1:0] lb_pt [MAX_LINKS];

    logic [MAX_SWITCHES-1:0] adj_reg [MAX_SWITCHES];
    logic [DIST_BITS-1:0]    dist_reg [MAX_SWITCHES];
    logic [SW_BITS-1:0]      pred_reg [MAX_SWITCHES];
    logic [MAX_SWITCHES-1:0] reached_reg, visited_reg;
    logic [5:0]              flags_reg [MAX_LINKS];

    logic [CNT_BITS-1:0] li_reg;      // link cursor
    logic [5:0]          j_reg;       // switch cursor
    logic [SW_BITS-1:0]  u_reg, best_u_reg;
    logic [DIST_BITS-1:0] best_d_reg;
    logic                found_reg;
    logic [PORT_BITS-1:0] bp_reg;
    logic [LK_BITS-1:0]   bl_reg;
    logic                 bbit_reg;   // 0 none
    logic                 bsideb_reg; // 1: end b is the root port

    assign cfg_ready = 1'b1;
    assign s_ready = (state_reg == ST_LOAD);
    assign n_act = (count_reg == 6'd0) ? 6'd1 :
                   (count_reg > 6'(MAX_SWITCHES)) ? 6'(MAX_SWITCHES) : count_reg;

    logic [LK_BITS-1:0] li;
    logic [SW_BITS-1:0] jj, ca, cb;
    assign li = li_reg[LK_BITS-1:0];
    assign jj = j_reg[SW_BITS-1:0];
    assign ca = la_sw[li];
    assign cb = lb_sw[li];

    // distance keys for the designated compare; 7th bit marks unreachable
    logic [DIST_BITS:0] ka, kb;
    assign ka = ({1'b0, ca} >= n_act || !reached_reg[ca]) ? {1'b1, {DIST_BITS{1'b0}}}
                                                         : {1'b0, dist_reg[ca]};
    assign kb = ({1'b0, cb} >= n_act || !reached_reg[cb]) ? {1'b1, {DIST_BITS{1'b0}}}
                                                         : {1'b0, dist_reg[cb]};

    // root port candidate for switch u_reg with predecessor pred_reg[u_reg]
    logic [SW_BITS-1:0] q;
    logic cand_a, cand_b;
    logic [PORT_BITS-1:0] far;
    assign q = pred_reg[u_reg];
    assign cand_a = (ca == u_reg) && (cb == q);
    assign cand_b = !cand_a && (cb == u_reg) && (ca == q);
    assign far = cand_a ? lb_pt[li] : la_pt[li];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= 6'd1;
            total_reg <= '0;
            m_valid <= 1'b0;
        end else begin
            if (cfg_valid) count_reg <= cfg_data;
            case (state_reg)
                ST_LOAD: begin
                    if (s_valid) begin
                        if (total_reg < CNT_BITS'(MAX_LINKS)) begin
                            la_sw[total_reg[LK_BITS-1:0]] <= s_data.end_a_switch;
                            la_pt[total_reg[LK_BITS-1:0]] <= s_data.end_a_port;
                            lb_sw[total_reg[LK_BITS-1:0]] <= s_data.end_b_switch;
                            lb_pt[total_reg[LK_BITS-1:0]] <= s_data.end_b_port;
                            total_reg <= total_reg + 1'b1;
                        end
                        if (s_data.last_link) begin
                            for (int k = 0; k < MAX_SWITCHES; k++) adj_reg[k] <= '0;
                            for (int k = 0; k < MAX_LINKS; k++) flags_reg[k] <= '0;
                            li_reg <= '0;
                            state_reg <= ST_ADJ;
                        end
                    end
                end
                // one link per cycle into the adjacency map
                ST_ADJ: begin
                    if (li_reg >= total_reg) begin
                        reached_reg <= MAX_SWITCHES'(1);
                        visited_reg <= MAX_SWITCHES'(1);
                        dist_reg[0] <= '0;
                        u_reg <= '0;
                        best_d_reg <= '0;
                        j_reg <= '0;
                        state_reg <= ST_RELAX;
                    end else begin
                        if ({1'b0, ca} < n_act && {1'b0, cb} < n_act && ca != cb) begin
                            adj_reg[ca][cb] <= 1'b1;
                            adj_reg[cb][ca] <= 1'b1;
                        end
                        li_reg <= li_reg + 1'b1;
                    end
                end
                // scan for closest unvisited reached switch
                ST_SEL: begin
                    if (j_reg >= n_act) begin
                        if (!found_reg) begin
                            u_reg <= SW_BITS'(1);
                            j_reg <= 6'd1;
                            state_reg <= ST_RPSW;
                        end else begin
                            u_reg <= best_u_reg;
                            visited_reg[best_u_reg] <= 1'b1;
                            j_reg <= '0;
                            state_reg <= ST_RELAX;
                        end
                    end else begin
                        if (!visited_reg[jj] && reached_reg[jj] &&
                            (!found_reg || dist_reg[jj] < best_d_reg)) begin
                            found_reg <= 1'b1;
                            best_d_reg <= dist_reg[jj];
                            best_u_reg <= jj;
                        end
                        j_reg <= j_reg + 1'b1;
                    end
                end
                // relax neighbors of u
                ST_RELAX: begin
                    if (j_reg >= n_act) begin
                        j_reg <= '0;
                        found_reg <= 1'b0;
                        state_reg <= ST_SEL;
                    end else begin
                        if (adj_reg[u_reg][jj] &&
                            (!reached_reg[jj] || dist_reg[jj] > best_d_reg + 1'b1)) begin
                            reached_reg[jj] <= 1'b1;
                            dist_reg[jj] <= best_d_reg + 1'b1;
                            pred_reg[jj] <= u_reg;
                        end
                        j_reg <= j_reg + 1'b1;
                    end
                end
                // next switch for root port election
                ST_RPSW: begin
                    if (j_reg >= n_act) begin
                        li_reg <= '0;
                        state_reg <= ST_DESIG;
                    end else if (!reached_reg[jj]) begin
                        j_reg <= j_reg + 1'b1;
                    end else begin
                        u_reg <= jj;
                        li_reg <= '0;
                        bbit_reg <= 1'b0;
                        state_reg <= ST_RPLINK;
                    end
                end
                ST_RPLINK: begin
                    if (li_reg >= total_reg) begin
                        state_reg <= ST_RPSET;
                    end else begin
                        if ((cand_a || cand_b) && (!bbit_reg || far < bp_reg)) begin
                            bbit_reg <= 1'b1;
                            bp_reg <= far;
                            bl_reg <= li;
                            bsideb_reg <= cand_b;
                        end
                        li_reg <= li_reg + 1'b1;
                    end
                end
                ST_RPSET: begin
                    if (bbit_reg) begin
                        if (bsideb_reg) flags_reg[bl_reg][3] <= 1'b1;
                        else flags_reg[bl_reg][0] <= 1'b1;
                    end
                    j_reg <= j_reg + 1'b1;
                    state_reg <= ST_RPSW;
                end
                // designated / blocked per link
                ST_DESIG: begin
                    if (li_reg >= total_reg) begin
                        li_reg <= '0;
                        state_reg <= (total_reg == '0) ? ST_LOAD : ST_EMIT;
                    end else begin
                        if (ca == '0) flags_reg[li][1] <= 1'b1;
                        else if (cb == '0) flags_reg[li][4] <= 1'b1;
                        else if (flags_reg[li][0] && !flags_reg[li][3])
                            flags_reg[li][4] <= 1'b1;
                        else if (flags_reg[li][3] && !flags_reg[li][0])
                            flags_reg[li][1] <= 1'b1;
                        else if ((ka != kb) ? (ka < kb) : (ca < cb)) begin
                            flags_reg[li][1] <= 1'b1;
                            flags_reg[li][5] <= 1'b1;
                        end else begin
                            flags_reg[li][4] <= 1'b1;
                            flags_reg[li][2] <= 1'b1;
                        end
                        li_reg <= li_reg + 1'b1;
                    end
                end
                ST_EMIT: begin
                    m_valid <= 1'b1;
                    m_data.link_index <= 5'(li);
                    m_data.a_root_port <= flags_reg[li][0];
                    m_data.a_designated <= flags_reg[li][1];
                    m_data.a_blocked <= flags_reg[li][2];
                    m_data.b_root_port <= flags_reg[li][3];
                    m_data.b_designated <= flags_reg[li][4];
                    m_data.b_blocked <= flags_reg[li][5];
                    m_data.last_result <= (li_reg + 1'b1 == total_reg);
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (m_ready) begin
                        m_valid <= 1'b0;
                        if (li_reg + 1'b1 == total_reg) begin
                            total_reg <= '0;
                            state_reg <= ST_LOAD;
                        end else begin
                            li_reg <= li_reg + 1'b1;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end
endmodule
